@@ src/pid_controller_position_delta_macros.svh @@
// Assertion macros for the PID controller block.
// Each macro samples on clock and is disabled while reset is high.
`ifndef PID_CONTROLLER_POSITION_DELTA_MACROS_SVH
`define PID_CONTROLLER_POSITION_DELTA_MACROS_SVH

// Check a consequent in the same cycle as its antecedent.
`define PCPD_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Check a consequent in the cycle after its antecedent.
`define PCPD_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ src/pcpd_pkg.sv @@
// Shared types and constants for the PID controller block.
// No dependencies; every other file of the block but the macros header uses it.
`timescale 1ns / 1ps

package pcpd_pkg;

   // Default parameter values
   localparam int SAMPLE_WIDTH_DEF   = 16;
   localparam int GAIN_FRAC_BITS_DEF = 8;

   // Fixed field widths
   localparam int GAIN_W     = 16;
   localparam int LIMIT_W    = 23;
   localparam int DRIVE_W    = 24;
   localparam int ESUM_W     = 32;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 23;

   localparam logic [LIMIT_W-1:0] LIMIT_RESET = {LIMIT_W{1'b1}};

   typedef enum logic {
      MODE_POSITIONAL = 1'b0,
      MODE_DELTA      = 1'b1
   } mode_type;

   typedef enum logic {
      REQ_COMPUTE = 1'b0,
      REQ_CLEAR   = 1'b1
   } req_kind_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MODE     = 3'd0,
      CSR_GAIN_P   = 3'd1,
      CSR_GAIN_I   = 3'd2,
      CSR_GAIN_D   = 3'd3,
      CSR_MAX_OUT  = 3'd4,
      CSR_MAX_IOUT = 3'd5
   } csr_index_type;

   typedef struct packed {
      mode_type                  mode;
      logic signed [GAIN_W-1:0]  gain_p;
      logic signed [GAIN_W-1:0]  gain_i;
      logic signed [GAIN_W-1:0]  gain_d;
      logic [LIMIT_W-1:0]        max_out;
      logic [LIMIT_W-1:0]        max_iout;
   } cfg_type;

endpackage

@@ src/pcpd_ifs.sv @@
// Valid/ready channel interfaces for the PID controller block.
// Depends on pcpd_pkg for widths.
`timescale 1ns / 1ps

interface pcpd_req_if #(
   parameter int SAMPLE_WIDTH = pcpd_pkg::SAMPLE_WIDTH_DEF
);
   logic                           valid;
   logic                           ready;
   logic                           req_type;
   logic signed [SAMPLE_WIDTH-1:0] target;
   logic signed [SAMPLE_WIDTH-1:0] measured;

   modport source (output valid, req_type, target, measured, input ready);
   modport sink   (input valid, req_type, target, measured, output ready);
endinterface

interface pcpd_rsp_if;
   logic                                   valid;
   logic                                   ready;
   logic signed [pcpd_pkg::DRIVE_W-1:0]    drive;

   modport source (output valid, drive, input ready);
   modport sink   (input valid, drive, output ready);
endinterface

interface pcpd_csr_if;
   logic                                valid;
   logic                                ready;
   logic [pcpd_pkg::CSR_IDX_W-1:0]      index;
   logic [pcpd_pkg::CSR_DATA_W-1:0]     data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

@@ src/pid_controller_position_delta.sv @@
// PID controller, positional and incremental forms. Takes one item per clock
// cycle while the result is not stalled; each item is held in the input
// register, then its result in the result register, from which it transfers
// out. The history (last two errors, error sum, last output)
// is updated as an item moves from the input register to the result register,
// so the next item sees it at once; the step between them is one pass through
// the error differences, three signed gain products and the output clamp.
// A stalled result holds the result register and, behind it, the input
// register; the input side takes a new item whenever the input register is
// empty or moves. Configuration writes are accepted every cycle and must only
// be issued while no item is in flight. Depends on pcpd_pkg, pcpd_ifs, pcpd_csr, pcpd_calc.
`timescale 1ns / 1ps
`include "pid_controller_position_delta_macros.svh"

module pid_controller_position_delta #(
   parameter int SAMPLE_WIDTH   = pcpd_pkg::SAMPLE_WIDTH_DEF,
   parameter int GAIN_FRAC_BITS = pcpd_pkg::GAIN_FRAC_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   pcpd_req_if.sink    req_ch,
   pcpd_rsp_if.source  rsp_ch,
   pcpd_csr_if.sink    csr_ch
);
   import pcpd_pkg::*;

   cfg_type cfg;

   // Input register
   logic                           in_valid_ff;
   logic                           in_valid_in;
   req_kind_type                   in_type_ff;
   logic signed [SAMPLE_WIDTH-1:0] in_target_ff;
   logic signed [SAMPLE_WIDTH-1:0] in_measured_ff;

   // Result register
   logic                           out_valid_ff;
   logic                           out_valid_in;
   logic signed [DRIVE_W-1:0]      drive_ff;

   // Controller history
   logic signed [SAMPLE_WIDTH:0]   err_last_ff;
   logic signed [SAMPLE_WIDTH:0]   err_prev_ff;
   logic signed [ESUM_W-1:0]       esum_ff;
   logic signed [DRIVE_W-1:0]      acc_ff;
   logic signed [SAMPLE_WIDTH:0]   err_last_in;
   logic signed [SAMPLE_WIDTH:0]   err_prev_in;
   logic signed [ESUM_W-1:0]       esum_in;
   logic signed [DRIVE_W-1:0]      drive_in;

   logic                           advance;
   logic                           take_req;

   // Check helpers
   logic                                         clear_step;
   logic                                         hist_zero;
   logic [ESUM_W+DRIVE_W+2*(SAMPLE_WIDTH+1)-1:0] hist_bits;

   pcpd_csr u_csr (
      .clock  (clock),
      .reset  (reset),
      .csr_ch (csr_ch),
      .cfg    (cfg)
   );

   pcpd_calc #(
      .SAMPLE_WIDTH   (SAMPLE_WIDTH),
      .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
   ) u_calc (
      .cfg           (cfg),
      .clear         (in_type_ff == REQ_CLEAR),
      .target        (in_target_ff),
      .measured      (in_measured_ff),
      .err_last      (err_last_ff),
      .err_prev      (err_prev_ff),
      .esum          (esum_ff),
      .acc           (acc_ff),
      .err_last_next (err_last_in),
      .err_prev_next (err_prev_in),
      .esum_next     (esum_in),
      .drive         (drive_in)
   );

   // Move the item on when the result register is free or being emptied
   assign advance  = in_valid_ff && (!out_valid_ff || rsp_ch.ready);
   assign take_req = req_ch.valid && req_ch.ready;

   assign req_ch.ready = !in_valid_ff || advance;
   assign rsp_ch.valid = out_valid_ff;
   assign rsp_ch.drive = drive_ff;

   // Valid flags of both registers
   always_comb begin
      in_valid_in  = take_req || (in_valid_ff && !advance);
      out_valid_in = advance || (out_valid_ff && !rsp_ch.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Capture a request transfer
   always_ff @(posedge clock) begin
      if (take_req) begin
         in_type_ff     <= req_kind_type'(req_ch.req_type);
         in_target_ff   <= req_ch.target;
         in_measured_ff <= req_ch.measured;
      end
   end

   // Load the result register
   always_ff @(posedge clock) begin
      if (advance) begin
         drive_ff <= drive_in;
      end
   end

   // Advance the history with each computed item
   always_ff @(posedge clock) begin
      if (reset) begin
         err_last_ff <= '0;
         err_prev_ff <= '0;
         esum_ff     <= '0;
         acc_ff      <= '0;
      end else if (advance) begin
         err_last_ff <= err_last_in;
         err_prev_ff <= err_prev_in;
         esum_ff     <= esum_in;
         acc_ff      <= drive_in;
      end
   end

   // Checks
   assign clear_step = advance && (in_type_ff == REQ_CLEAR);
   assign hist_zero  = (drive_ff == '0) && (esum_ff == '0) && (err_last_ff == '0)
                       && (acc_ff == '0);
   assign hist_bits  = {esum_ff, acc_ff, err_last_ff, err_prev_ff};

   `PCPD_ASSERT_NEXT(a_advance_fills_out, advance, out_valid_ff, "result register not loaded")
   `PCPD_ASSERT_NEXT(a_acc_tracks_drive, advance, acc_ff == drive_ff, "stored output differs")
   `PCPD_ASSERT_NEXT(a_clear_zeroes, clear_step, hist_zero, "clear left history")
   `PCPD_ASSERT_NEXT(a_history_holds, !advance, $stable(hist_bits), "history moved")
   `PCPD_ASSERT_SAME(a_ready_when_empty, !in_valid_ff, req_ch.ready, "input refused while empty")

endmodule

@@ src/pcpd_csr.sv @@
// Configuration registers of the PID controller block.
// Depends on pcpd_pkg and the pcpd_csr_if interface.
`timescale 1ns / 1ps

module pcpd_csr (
   input  logic              clock,
   input  logic              reset,
   pcpd_csr_if.sink          csr_ch,
   output pcpd_pkg::cfg_type cfg
);
   import pcpd_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // Always take a write; unknown indexes fall through
   assign csr_ch.ready = 1'b1;

   // Decode the register index of a write transfer
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_ch.valid) begin
         case (csr_ch.index)
            CSR_MODE:     cfg_in.mode     = mode_type'(csr_ch.data[0]);
            CSR_GAIN_P:   cfg_in.gain_p   = csr_ch.data[GAIN_W-1:0];
            CSR_GAIN_I:   cfg_in.gain_i   = csr_ch.data[GAIN_W-1:0];
            CSR_GAIN_D:   cfg_in.gain_d   = csr_ch.data[GAIN_W-1:0];
            CSR_MAX_OUT:  cfg_in.max_out  = csr_ch.data[LIMIT_W-1:0];
            CSR_MAX_IOUT: cfg_in.max_iout = csr_ch.data[LIMIT_W-1:0];
            default:      cfg_in          = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.mode     <= MODE_POSITIONAL;
         cfg_ff.gain_p   <= '0;
         cfg_ff.gain_i   <= '0;
         cfg_ff.gain_d   <= '0;
         cfg_ff.max_out  <= LIMIT_RESET;
         cfg_ff.max_iout <= LIMIT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

@@ src/pcpd_calc.sv @@
// One control step of the PID controller: error, three gain products, clamps.
// Pure combinational; depends on pcpd_pkg.
`timescale 1ns / 1ps

module pcpd_calc #(
   parameter int SAMPLE_WIDTH   = pcpd_pkg::SAMPLE_WIDTH_DEF,
   parameter int GAIN_FRAC_BITS = pcpd_pkg::GAIN_FRAC_BITS_DEF
) (
   input  pcpd_pkg::cfg_type                     cfg,
   input  logic                                  clear,
   input  logic signed [SAMPLE_WIDTH-1:0]        target,
   input  logic signed [SAMPLE_WIDTH-1:0]        measured,
   input  logic signed [SAMPLE_WIDTH:0]          err_last,
   input  logic signed [SAMPLE_WIDTH:0]          err_prev,
   input  logic signed [pcpd_pkg::ESUM_W-1:0]    esum,
   input  logic signed [pcpd_pkg::DRIVE_W-1:0]   acc,
   output logic signed [SAMPLE_WIDTH:0]          err_last_next,
   output logic signed [SAMPLE_WIDTH:0]          err_prev_next,
   output logic signed [pcpd_pkg::ESUM_W-1:0]    esum_next,
   output logic signed [pcpd_pkg::DRIVE_W-1:0]   drive
);
   import pcpd_pkg::*;

   localparam int ERR_W = SAMPLE_WIDTH + 1;
   localparam int D1_W  = SAMPLE_WIDTH + 2;
   localparam int D2_W  = SAMPLE_WIDTH + 3;
   localparam int SW_W  = ESUM_W + 1;
   localparam int PP_W  = GAIN_W + D1_W;
   localparam int PI_W  = GAIN_W + ESUM_W;
   localparam int PD_W  = GAIN_W + D2_W;
   localparam int IT_W  = GAIN_W + ERR_W;
   localparam int ACC_W = GAIN_W + D2_W + 2;

   logic signed [ERR_W-1:0]  err;
   logic signed [D1_W-1:0]   diff1;
   logic signed [D2_W-1:0]   diff2;
   logic signed [SW_W-1:0]   sum_wide;
   logic signed [ESUM_W-1:0] esum_sat;
   logic signed [D1_W-1:0]   opnd_p;
   logic signed [ESUM_W-1:0] opnd_i;
   logic signed [D2_W-1:0]   opnd_d;
   logic signed [PP_W-1:0]   prod_p;
   logic signed [PI_W-1:0]   prod_i;
   logic signed [PD_W-1:0]   prod_d;
   logic signed [PP_W-1:0]   term_p;
   logic signed [PI_W-1:0]   shift_i;
   logic signed [PI_W-1:0]   clamp_i;
   logic signed [PI_W-1:0]   lim_i;
   logic signed [IT_W-1:0]   term_i;
   logic signed [PD_W-1:0]   term_d;
   logic signed [ACC_W-1:0]  base;
   logic signed [ACC_W-1:0]  total;
   logic signed [ACC_W-1:0]  lim_o;
   logic signed [ACC_W-1:0]  res;
   logic                     is_delta;

   assign is_delta = (cfg.mode == MODE_DELTA);

   // Error and its first and second differences
   always_comb begin
      err   = ERR_W'(target) - ERR_W'(measured);
      diff1 = D1_W'(err) - D1_W'(err_last);
      diff2 = D2_W'(err) - (D2_W'(err_last) <<< 1) + D2_W'(err_prev);
   end

   // Saturating error sum
   always_comb begin
      sum_wide = SW_W'(esum) + SW_W'(err);
      if (sum_wide[ESUM_W] != sum_wide[ESUM_W-1]) begin
         esum_sat = sum_wide[ESUM_W] ? {1'b1, {(ESUM_W-1){1'b0}}}
                                     : {1'b0, {(ESUM_W-1){1'b1}}};
      end else begin
         esum_sat = sum_wide[ESUM_W-1:0];
      end
   end

   // Select multiplier operands for the active form
   always_comb begin
      if (is_delta) begin
         opnd_p = diff1;
         opnd_i = ESUM_W'(err);
         opnd_d = diff2;
      end else begin
         opnd_p = D1_W'(err);
         opnd_i = esum_sat;
         opnd_d = D2_W'(diff1);
      end
   end

   // Gain products, scaled down by the gain fraction
   always_comb begin
      prod_p  = PP_W'(cfg.gain_p) * PP_W'(opnd_p);
      prod_i  = PI_W'(cfg.gain_i) * PI_W'(opnd_i);
      prod_d  = PD_W'(cfg.gain_d) * PD_W'(opnd_d);
      term_p  = prod_p >>> GAIN_FRAC_BITS;
      shift_i = prod_i >>> GAIN_FRAC_BITS;
      term_d  = prod_d >>> GAIN_FRAC_BITS;
   end

   // Clamp the integral term in positional form
   always_comb begin
      lim_i = PI_W'($signed({1'b0, cfg.max_iout}));
      if (shift_i > lim_i) begin
         clamp_i = lim_i;
      end else if (shift_i < -lim_i) begin
         clamp_i = -lim_i;
      end else begin
         clamp_i = shift_i;
      end
      term_i = is_delta ? IT_W'(shift_i) : IT_W'(clamp_i);
   end

   // Sum the terms and clamp to the output limit
   always_comb begin
      base  = is_delta ? ACC_W'(acc) : '0;
      total = base + ACC_W'(term_p) + ACC_W'(term_i) + ACC_W'(term_d);
      lim_o = ACC_W'($signed({1'b0, cfg.max_out}));
      if (total > lim_o) begin
         res = lim_o;
      end else if (total < -lim_o) begin
         res = -lim_o;
      end else begin
         res = total;
      end
   end

   // Next history; a clear drops all of it
   always_comb begin
      if (clear) begin
         err_last_next = '0;
         err_prev_next = '0;
         esum_next     = '0;
         drive         = '0;
      end else begin
         err_last_next = err;
         err_prev_next = err_last;
         esum_next     = is_delta ? esum : esum_sat;
         drive         = res[DRIVE_W-1:0];
      end
   end

endmodule
